@@ hdl/i2c_master_bit_sequencer_defines.svh @@
// Assertion macros for the I2C master bit sequencer.
// No dependencies.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
// Property that must hold on every clock edge outside reset.
`define I2CM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

@@ hdl/i2cm_pkg.sv @@
// Package for the I2C master bit sequencer: constants, phase enum, item types.
// No dependencies.
package i2cm_pkg;
   localparam int MaxBytes = 16;
   localparam int BufIdxW = $clog2(MaxBytes);
   localparam int CntW = $clog2(MaxBytes + 1);

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TXB, PH_TXK_A, PH_TXK_B, PH_TXK_C,
      PH_RXB, PH_RXK_A, PH_RXK_B, PH_RXK_C, PH_SP_A, PH_SP_B, PH_SP_C
   } phase_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       sda_sample;
      logic [7:0] data_byte;
      logic [6:0] target_addr;
      logic [7:0] reg_addr;
      logic [4:0] byte_count;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic       nacked;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       rx_last;
      logic       wdt_feed;
   } rsp_type;
endpackage

@@ hdl/i2cm_req_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on i2cm_pkg.
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/i2cm_queue.sv @@
// Two-entry beat queue between the front and the back.
// Depends on i2cm_pkg.
module i2cm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  i2cm_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output i2cm_pkg::req_type out_data
);
   import i2cm_pkg::*;
   req_type    mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_data;
   end
endmodule

@@ hdl/i2cm_engine.sv @@
// Back end: bus phase sequencer, write buffer and result register.
// Depends on i2cm_pkg.
module i2cm_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  i2cm_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output i2cm_pkg::rsp_type out_data
);
   import i2cm_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [1:0]          unit_ff, unit_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          shift_ff, shift_in;
   logic [CntW-1:0]     bidx_ff, bidx_in;
   logic [7:0]          buf_ff [MaxBytes];
   logic [CntW-1:0]     loaded_ff, loaded_in;
   logic [6:0]          addr_ff, addr_in;
   logic [7:0]          reg_ff, reg_in;
   logic [CntW-1:0]     hcnt_ff, hcnt_in;
   logic                rd_ff, rd_in, scl_ff, scl_in, sda_ff, sda_in, nack_ff, nack_in;
   logic                ov_ff;
   rsp_type             out_ff, rsp;
   logic                take, buf_we;
   logic [CntW-1:0]     cnt_w;
   logic [CntW:0]       bidx_p1;
   logic                last, fire;

   assign in_ready  = !ov_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data  = out_ff;
   assign bidx_p1   = {1'b0, bidx_ff} + 1'b1;
   assign fire      = take && in_data.operation == OP_TICK && phase_ff != PH_IDLE;
   // byte_count saturated to the buffer depth
   assign cnt_w = (in_data.byte_count > 5'(MaxBytes)) ? CntW'(MaxBytes)
                                                      : CntW'(in_data.byte_count);

   always_comb begin
      phase_in = phase_ff; unit_in = unit_ff; bit_in = bit_ff; shift_in = shift_ff;
      bidx_in = bidx_ff; loaded_in = loaded_ff; addr_in = addr_ff; reg_in = reg_ff;
      hcnt_in = hcnt_ff; rd_in = rd_ff; scl_in = scl_ff; sda_in = sda_ff;
      nack_in = nack_ff; buf_we = 1'b0;
      rsp = '0;
      last = (unit_ff == 2'd1);
      if (take && in_data.operation != OP_TICK) begin
         if (phase_ff == PH_IDLE) begin
            if (in_data.operation == OP_LOAD) begin
               if (loaded_ff < CntW'(MaxBytes)) begin
                  buf_we = 1'b1;
                  loaded_in = loaded_ff + 1'b1;
               end
            end else begin
               addr_in = in_data.target_addr;
               reg_in  = in_data.reg_addr;
               nack_in = 1'b0; bidx_in = '0; unit_in = 2'd0;
               if (in_data.operation == OP_WRITE) begin
                  rd_in = 1'b0;
                  hcnt_in = (cnt_w < loaded_ff) ? cnt_w : loaded_ff;
                  loaded_in = '0;
               end else begin
                  rd_in = 1'b1;
                  hcnt_in = cnt_w;
               end
               shift_in = {in_data.target_addr, 1'b0};
               phase_in = PH_ST_A;
            end
         end
         rsp.busy_res = (phase_in != PH_IDLE);
      end else if (fire) begin
         rsp.busy_res = 1'b1;
         case (phase_ff)
            PH_ST_A: if (unit_ff == 2'd0) begin sda_in = 1'b1; scl_in = 1'b1; end
            PH_ST_B: if (unit_ff == 2'd0) sda_in = 1'b0;
            PH_ST_C: if (unit_ff == 2'd0) scl_in = 1'b0;
            PH_TXB: begin
               last = (unit_ff == 2'd3);
               case (unit_ff)
                  2'd0: scl_in = 1'b0;
                  2'd1: sda_in = shift_ff[bit_ff];
                  2'd2: scl_in = 1'b1;
                  default: rsp.wdt_feed = 1'b1;
               endcase
            end
            PH_TXK_A: if (unit_ff == 2'd0) scl_in = 1'b0; else sda_in = 1'b1;
            PH_TXK_B: if (unit_ff == 2'd0) begin
               scl_in = 1'b1; nack_in = in_data.sda_sample;
            end
            PH_TXK_C: if (unit_ff == 2'd0) scl_in = 1'b0;
            PH_RXB: begin
               last = (unit_ff == 2'd3);
               if (unit_ff == 2'd0) begin scl_in = 1'b0; sda_in = 1'b1; end
               else if (unit_ff == 2'd2) begin
                  scl_in = 1'b1;
                  if (in_data.sda_sample) shift_in[bit_ff] = 1'b1;
               end else if (unit_ff == 2'd3) rsp.wdt_feed = 1'b1;
            end
            PH_RXK_A: if (unit_ff == 2'd0) scl_in = 1'b0;
                      else sda_in = !(bidx_p1 < {1'b0, hcnt_ff});
            PH_RXK_B: if (unit_ff == 2'd0) scl_in = 1'b1;
            PH_RXK_C: if (unit_ff == 2'd0) scl_in = 1'b0;
            PH_SP_A: if (unit_ff == 2'd0) begin sda_in = 1'b0; scl_in = 1'b0; end
            PH_SP_B: if (unit_ff == 2'd0) scl_in = 1'b1;
            PH_SP_C: if (unit_ff == 2'd0) sda_in = 1'b1;
            default: ;
         endcase
         if (!last) unit_in = unit_ff + 2'd1;
         else begin
            unit_in = 2'd0;
            case (phase_ff)
               PH_ST_C: begin phase_in = PH_TXB; bit_in = 3'd7; end
               PH_TXB, PH_RXB: begin
                  if (bit_ff == 3'd0)
                     phase_in = (phase_ff == PH_TXB) ? PH_TXK_A : PH_RXK_A;
                  else bit_in = bit_ff - 3'd1;
               end
               PH_TXK_C: begin
                  if (nack_in) phase_in = PH_SP_A;
                  else if (!rd_ff) begin
                     rsp.wdt_feed = (bidx_ff != '0);
                     bidx_in = bidx_p1[CntW-1:0];
                     if (bidx_ff < hcnt_ff) begin
                        shift_in = buf_ff[bidx_ff[BufIdxW-1:0]];
                        bit_in = 3'd7; phase_in = PH_TXB;
                     end else phase_in = PH_SP_A;
                  end else if (bidx_ff == '0) begin
                     bidx_in = CntW'(1); shift_in = reg_ff; bit_in = 3'd7;
                     phase_in = PH_TXB;
                  end else if (bidx_ff == CntW'(1)) begin
                     bidx_in = CntW'(2); shift_in = {addr_ff, 1'b1};
                     phase_in = PH_ST_A;
                  end else begin
                     bidx_in = '0;
                     if (hcnt_ff == '0) phase_in = PH_SP_A;
                     else begin shift_in = '0; bit_in = 3'd7; phase_in = PH_RXB; end
                  end
               end
               PH_RXK_C: begin
                  rsp.rx_valid = 1'b1; rsp.rx_byte = shift_ff; rsp.wdt_feed = 1'b1;
                  rsp.rx_last = (bidx_p1 >= {1'b0, hcnt_ff});
                  bidx_in = bidx_p1[CntW-1:0];
                  if (bidx_p1 < {1'b0, hcnt_ff}) begin
                     shift_in = '0; bit_in = 3'd7; phase_in = PH_RXB;
                  end else phase_in = PH_SP_A;
               end
               PH_SP_C: begin
                  phase_in = PH_IDLE; rsp.done_res = 1'b1; rsp.nacked = nack_ff;
               end
               default: phase_in = phase_type'(phase_ff + 4'd1);
            endcase
         end
      end
      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; unit_ff <= '0; bit_ff <= 3'd7; shift_ff <= '0;
         bidx_ff <= '0; loaded_ff <= '0; addr_ff <= '0; reg_ff <= '0;
         hcnt_ff <= '0; rd_ff <= 1'b0; scl_ff <= 1'b1; sda_ff <= 1'b1;
         nack_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; unit_ff <= unit_in; bit_ff <= bit_in;
         shift_ff <= shift_in; bidx_ff <= bidx_in; loaded_ff <= loaded_in;
         addr_ff <= addr_in; reg_ff <= reg_in; hcnt_ff <= hcnt_in; rd_ff <= rd_in;
         scl_ff <= scl_in; sda_ff <= sda_in; nack_ff <= nack_in;
         if (take) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) out_ff <= rsp;
      if (buf_we) buf_ff[loaded_ff[BufIdxW-1:0]] <= in_data.data_byte;
   end
endmodule

@@ hdl/i2c_master_bit_sequencer.sv @@
// Top level of the I2C master bit sequencer: queue front, phase engine back.
// Depends on i2cm_pkg, i2cm_req_if/i2cm_rsp_if, i2cm_queue, i2cm_engine.
//
//  channel  dir  beat
//  req      in   operation, sda_sample, data_byte, target_addr, reg_addr, byte_count
//  rsp      out  scl/sda levels, busy, done, nacked, rx byte/valid/last, wdt_feed
//
// One beat per clock sustained while rsp is ready; each req beat yields one rsp beat.
// Each beat is registered in the queue, then in the engine's rsp register.
// The queue holds two beats, so req can still be taken under rsp stall until it fills.
// Reset is synchronous; bus lines come out of reset released high.
module i2c_master_bit_sequencer (
   input logic clock,
   input logic reset,
   i2cm_req_if.sink   req,
   i2cm_rsp_if.source rsp
);
   import i2cm_pkg::*;
`include "i2c_master_bit_sequencer_defines.svh"

   logic    q_valid, q_ready;
   req_type q_data;

   // front: accept and buffer request beats
   i2cm_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // back: run bus phases, one unit per tick beat
   i2cm_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );

   `I2CM_ASSERT(a_done_busy, !(rsp.valid && rsp.payload.done_res) || rsp.payload.busy_res, "done without busy")
   `I2CM_ASSERT(a_nack_done, !(rsp.valid && rsp.payload.nacked) || rsp.payload.done_res, "nacked without done")
   `I2CM_ASSERT_NEXT(a_stall_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload), "rsp dropped under stall")
endmodule

@@ test/i2cm_tb_if.sv @@
`timescale 1ns / 1ps
// Testbench constants: idle chance per side and the run-length limit.
// Depends on i2cm_pkg; the channel interfaces come from the RTL.
package i2cm_tb_pkg;
   import i2cm_pkg::*;

   // Chance in a hundred that a side idles on a given cycle.
   localparam int IdlePct = 21;
   localparam int CycleLimit = 40000;
endpackage

@@ test/i2cm_bus_checker.sv @@
`timescale 1ns / 1ps
// Checker: watches req and rsp beats, predicts each rsp beat, compares fields.
// Depends on i2cm_pkg and the channel interfaces.
module i2cm_bus_checker
   import i2cm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   i2cm_req_if      req,
   i2cm_rsp_if      rsp,
   output int       fail_count,
   output int       pending
);
   phase_type  ph;
   logic [1:0] unit;
   logic [2:0] bit_idx;
   logic [7:0] shreg;
   logic [4:0] byte_idx;
   logic [7:0] wbuf [MaxBytes];
   logic [4:0] loaded, hcount;
   logic [6:0] haddr;
   logic [7:0] hreg;
   logic       rd, scl, sda, nack;
   rsp_type    expected_beats [$];

   // Sets up the next byte to shift out.
   function automatic void load_tx(input logic [7:0] b);
      shreg = b; bit_idx = 3'd7; ph = PH_TXB;
   endfunction

   // Decides the follow-up once the ACK slot after a sent byte ends.
   function automatic logic after_ack();
      logic f;
      f = 1'b0;
      if (nack) begin
         ph = PH_SP_A;
      end else if (!rd) begin
         if (byte_idx >= 5'd1) f = 1'b1;
         byte_idx++;
         if (byte_idx - 5'd1 < hcount) load_tx(wbuf[4'(byte_idx - 5'd1)]);
         else ph = PH_SP_A;
      end else if (byte_idx == 5'd0) begin
         byte_idx = 5'd1; load_tx(hreg);
      end else if (byte_idx == 5'd1) begin
         byte_idx = 5'd2; shreg = {haddr, 1'b1}; ph = PH_ST_A;
      end else begin
         byte_idx = 5'd0;
         if (hcount == 5'd0) ph = PH_SP_A;
         else begin shreg = 8'd0; bit_idx = 3'd7; ph = PH_RXB; end
      end
      return f;
   endfunction

   // One time unit of bus sequencing.
   function automatic rsp_type time_unit(input logic sda_in);
      rsp_type r;
      phase_type cur;
      logic last;
      r = '0; cur = ph; last = (unit == 2'd1);
      case (cur)
         PH_ST_A: if (unit == 0) begin sda = 1; scl = 1; end
         PH_ST_B: if (unit == 0) sda = 0;
         PH_ST_C: if (unit == 0) scl = 0;
         PH_TXB: begin
            last = (unit == 2'd3);
            if (unit == 0) scl = 0;
            else if (unit == 1) sda = shreg[bit_idx];
            else if (unit == 2) scl = 1;
            else r.wdt_feed = 1;
         end
         PH_TXK_A: if (unit == 0) scl = 0; else sda = 1;
         PH_TXK_B: if (unit == 0) begin scl = 1; nack = sda_in; end
         PH_TXK_C: if (unit == 0) scl = 0;
         PH_RXB: begin
            last = (unit == 2'd3);
            if (unit == 0) begin scl = 0; sda = 1; end
            else if (unit == 2) begin scl = 1; if (sda_in) shreg[bit_idx] = 1'b1; end
            else if (unit == 3) r.wdt_feed = 1;
         end
         PH_RXK_A: if (unit == 0) scl = 0;
                   else sda = (byte_idx + 5'd1 < hcount) ? 1'b0 : 1'b1;
         PH_RXK_B: if (unit == 0) scl = 1;
         PH_RXK_C: if (unit == 0) scl = 0;
         PH_SP_A: if (unit == 0) begin sda = 0; scl = 0; end
         PH_SP_B: if (unit == 0) scl = 1;
         PH_SP_C: if (unit == 0) sda = 1;
         default: begin ph = PH_IDLE; last = 0; end
      endcase
      if (cur != PH_IDLE) begin
         if (!last) unit = unit + 2'd1;
         else begin
            unit = 2'd0;
            case (cur)
               PH_ST_C: begin ph = PH_TXB; bit_idx = 3'd7; end
               PH_TXB: if (bit_idx == 0) ph = PH_TXK_A; else bit_idx--;
               PH_TXK_C: r.wdt_feed = after_ack();
               PH_RXB: if (bit_idx == 0) ph = PH_RXK_A; else bit_idx--;
               PH_RXK_C: begin
                  r.rx_valid = 1; r.rx_byte = shreg; r.wdt_feed = 1;
                  r.rx_last = (byte_idx + 5'd1 >= hcount);
                  byte_idx++;
                  if (byte_idx < hcount) begin
                     shreg = 8'd0; bit_idx = 3'd7; ph = PH_RXB;
                  end else ph = PH_SP_A;
               end
               PH_SP_C: begin ph = PH_IDLE; r.done_res = 1; r.nacked = nack; end
               default: ph = phase_type'(cur + 1);
            endcase
         end
      end
      r.scl_level = scl; r.sda_level = sda; r.busy_res = (cur != PH_IDLE);
      return r;
   endfunction

   function automatic rsp_type predict_bus(input req_type q);
      rsp_type r;
      r = '0;
      if (q.operation == OP_TICK) return time_unit(q.sda_sample);
      if (ph == PH_IDLE) begin
         if (q.operation == OP_LOAD) begin
            if (loaded < 5'(MaxBytes)) begin wbuf[loaded[3:0]] = q.data_byte; loaded++; end
         end else begin
            haddr = q.target_addr; hreg = q.reg_addr;
            nack = 0; byte_idx = 5'd0; unit = 2'd0;
            if (q.operation == OP_WRITE) begin
               rd = 0; hcount = (q.byte_count < loaded) ? q.byte_count : loaded;
               loaded = 5'd0;
            end else begin
               rd = 1;
               hcount = (q.byte_count < 5'(MaxBytes)) ? q.byte_count : 5'(MaxBytes);
            end
            shreg = {haddr, 1'b0}; ph = PH_ST_A;
         end
      end
      r.scl_level = scl; r.sda_level = sda; r.busy_res = (ph != PH_IDLE);
      return r;
   endfunction

   task automatic compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e, a;
      if (reset) begin
         ph = PH_IDLE; unit = 2'd0; bit_idx = 3'd7; shreg = 8'd0; byte_idx = 5'd0;
         loaded = 5'd0; haddr = 7'd0; hreg = 8'd0; hcount = 5'd0; rd = 0;
         scl = 1; sda = 1; nack = 0; fail_count = 0;
         expected_beats.delete();
         pending = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            a = rsp.payload;
            if (expected_beats.size() == 0) begin
               $error("rsp beat with nothing expected");
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               compare_field("scl_level", e.scl_level, a.scl_level);
               compare_field("sda_level", e.sda_level, a.sda_level);
               compare_field("busy_res", e.busy_res, a.busy_res);
               compare_field("done_res", e.done_res, a.done_res);
               compare_field("nacked", e.nacked, a.nacked);
               compare_field("rx_valid", e.rx_valid, a.rx_valid);
               compare_field("rx_byte", e.rx_byte, a.rx_byte);
               compare_field("rx_last", e.rx_last, a.rx_last);
               compare_field("wdt_feed", e.wdt_feed, a.wdt_feed);
            end
         end
         if (req.valid && req.ready) expected_beats.push_back(predict_bus(req.payload));
         pending = expected_beats.size();
      end
   end
endmodule

@@ test/i2c_master_bit_sequencer_tb.sv @@
`timescale 1ns / 1ps
// Top of the I2C master bit sequencer bench: clock, reset, stimulus, verdict.
// Depends on i2cm_pkg, the channel interfaces, i2cm_tb_pkg and i2cm_bus_checker.
module i2c_master_bit_sequencer_tb;
   import i2cm_pkg::*;
   import i2cm_tb_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending, cycle_count = 0;
   bit   calm;       // set: sender and receiver never idle
   bit   ack_low;    // target behavior for this transaction

   i2cm_req_if req ();
   i2cm_rsp_if rsp ();

   i2c_master_bit_sequencer u_top (.clock(clock), .reset(reset), .req(req), .rsp(rsp));
   i2cm_bus_checker u_chk (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .pending(pending));

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("[i2c_master_bit_sequencer] ERROR");
         $finish;
      end
   end

   // Receiver stalls at random unless in the calm stretch.
   initial rsp.ready = 1'b0;
   always @(posedge clock)
      rsp.ready <= reset ? 1'b0 : (calm || $urandom_range(99) >= IdlePct);

   // Drive one req beat, with optional idle cycles first; returns once accepted.
   task automatic send_beat(input req_type q);
      while (!calm && $urandom_range(99) < IdlePct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= q;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // Withdraw valid once the last beat of a burst is in.
   task automatic release_req();
      req.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [7:0] d,
                          input logic [6:0] addr, input logic [7:0] ra,
                          input logic [4:0] cnt, input logic sda_in);
      req_type q;
      q = '{op, sda_in, d, addr, ra, cnt};
      send_beat(q);
   endtask

   // Time units for one transaction; the target line is mostly ACK, random bits.
   task automatic run_ticks(input int n, input int nack_pct);
      repeat (n) send_op(OP_TICK, 8'($urandom), 7'($urandom), 8'($urandom),
                         5'($urandom),
                         ($urandom_range(99) < nack_pct) ? 1'b1
                                                         : (1'($urandom_range(1)) & ~ack_low));
   endtask

   task automatic write_txn(input int nbytes, input logic [4:0] cnt, input int nack_pct);
      int n;
      n = (int'(cnt) < nbytes) ? int'(cnt) : nbytes;
      repeat (nbytes) send_op(OP_LOAD, 8'($urandom), 7'($urandom), 8'($urandom),
                              5'($urandom), 1'($urandom));
      send_op(OP_WRITE, 8'($urandom), 7'($urandom), 8'($urandom), cnt, 1'($urandom));
      // start + address + data bytes of 38 units each + stop
      run_ticks(20 + 38 * (n + 1), nack_pct);
   endtask

   task automatic read_txn(input logic [4:0] cnt, input int nack_pct);
      int n;
      n = (int'(cnt) > MaxBytes) ? MaxBytes : int'(cnt);
      send_op(OP_READ, 8'($urandom), 7'($urandom), 8'($urandom), cnt, 1'($urandom));
      // two starts, three sent bytes and stop take 132 units, then 38 per read byte
      run_ticks(140 + 38 * n, nack_pct);
   endtask

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      calm = 1'b0;
      ack_low = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: full-buffer overflow, extremes, zero-length read, NACK ends.
      repeat (17) send_op(OP_LOAD, 8'hFF, 7'h7F, 8'hFF, 5'd31, 1'b1);
      send_op(OP_WRITE, 8'h00, 7'h7F, 8'h00, 5'd31, 1'b0);
      send_op(OP_READ, 8'h00, 7'h00, 8'h00, 5'd3, 1'b0); // ignored while busy
      run_ticks(60, 100);                                 // address refused
      send_op(OP_READ, 8'h00, 7'h00, 8'hFF, 5'd0, 1'b0);
      run_ticks(140, 0);
      send_op(OP_LOAD, 8'h00, 7'h00, 8'h00, 5'd0, 1'b0);
      send_op(OP_WRITE, 8'h00, 7'h55, 8'h00, 5'd0, 1'b0);
      run_ticks(60, 100);

      // Sender holds off until all beats are back.
      release_req();
      while (pending != 0) @(posedge clock);

      // Random transactions; the middle two run without idling.
      for (int t = 0; t < 4; t++) begin
         calm = (t >= 1 && t < 3);
         ack_low = ($urandom_range(3) != 0);
         case ($urandom_range(2))
            0: write_txn($urandom_range(3, 1), 5'($urandom_range(31)), 1);
            1: read_txn(5'($urandom_range(2, 1)), 1);
            default: begin   // noise
               repeat (8) send_op(2'($urandom), 8'($urandom), 7'($urandom), 8'($urandom),
                                  5'($urandom_range(6)), 1'($urandom));
               run_ticks(100, 3);
            end
         endcase
      end
      calm = 1'b0;

      release_req();
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[i2c_master_bit_sequencer] OK");
      end else begin
         $display("[i2c_master_bit_sequencer] ERROR");
      end
      $finish;
   end
endmodule

@@ files.f @@
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_req_if.sv
hdl/i2cm_queue.sv
hdl/i2cm_engine.sv
hdl/i2c_master_bit_sequencer.sv
test/i2cm_tb_if.sv
test/i2cm_bus_checker.sv
test/i2c_master_bit_sequencer_tb.sv
